FILE: design/fkdh_pkg.sv
// Shared types, constants and helpers for the DH forward kinematics core.
`timescale 1ns / 1ps
package fkdh_pkg;

	localparam int NUM_LINKS    = 6;
	localparam int CNT_W        = 4;
	localparam int CORDIC_ITERS = 28;
	localparam int IT_W         = 5;

	localparam logic signed [33:0] PI_Q       = 34'sd843314857;
	localparam logic signed [33:0] TWO_PI_Q   = 34'sd1686629713;
	localparam logic signed [33:0] HALF_PI_Q  = 34'sd421657428;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;

	localparam logic [1:0] REG_TOOL_X = 2'd0;
	localparam logic [1:0] REG_TOOL_Y = 2'd1;
	localparam logic [1:0] REG_TOOL_Z = 2'd2;

	typedef enum logic [1:0] {
		PH_LINK,
		PH_ROT,
		PH_TRN,
		PH_TOOL
	} phase_t;

	typedef struct packed {
		logic       capture;
		logic       cord_step;
		logic       cord_load;
		logic       cord_st_theta;
		logic       cord_st_alpha;
		logic       mul;
		logic       acc;
		logic       emit;
		logic       commit;
		logic       clear;
		phase_t     phase;
		logic [2:0] m;
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] k;
		logic [IT_W-1:0] iter;
		logic [2:0] link_idx;
		logic       tool;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [31:0] atan_q(input logic [IT_W-1:0] n);
		logic [31:0] v;
		case (n)
			5'd0:  v = 32'd210828714;
			5'd1:  v = 32'd124459457;
			5'd2:  v = 32'd65760959;
			5'd3:  v = 32'd33381289;
			5'd4:  v = 32'd16755422;
			5'd5:  v = 32'd8385879;
			5'd6:  v = 32'd4193963;
			5'd7:  v = 32'd2097109;
			5'd8:  v = 32'd1048571;
			5'd9:  v = 32'd524287;
			5'd10: v = 32'd262144;
			5'd11: v = 32'd131072;
			5'd12: v = 32'd65536;
			5'd13: v = 32'd32768;
			5'd14: v = 32'd16384;
			5'd15: v = 32'd8192;
			5'd16: v = 32'd4096;
			5'd17: v = 32'd2048;
			5'd18: v = 32'd1024;
			5'd19: v = 32'd512;
			5'd20: v = 32'd256;
			5'd21: v = 32'd128;
			5'd22: v = 32'd64;
			5'd23: v = 32'd32;
			5'd24: v = 32'd16;
			5'd25: v = 32'd8;
			5'd26: v = 32'd4;
			5'd27: v = 32'd2;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -36'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

FILE: design/fkdh_datapath.sv
// Datapath: CORDIC, shared multiplier/accumulator, chain and result registers.
`timescale 1ns / 1ps
module fkdh_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  fkdh_pkg::cmd_t      cmd,
	output fkdh_pkg::sts_t      sts,
	input  logic signed [31:0]  in_length,
	input  logic signed [31:0]  in_twist,
	input  logic signed [31:0]  in_offset,
	input  logic signed [31:0]  in_angle,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [2:0]          out_link_index,
	output logic [1:0]          out_row,
	output logic                out_tool,
	output logic signed [31:0]  out_col0,
	output logic signed [31:0]  out_col1,
	output logic signed [31:0]  out_col2,
	output logic signed [31:0]  out_col3,
	output logic                out_last
);
	import fkdh_pkg::*;

	logic signed [31:0] len_q, ofs_q, alpha_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic               cneg_q;
	logic signed [31:0] l_q [3][3];
	logic signed [31:0] lt_q [2];
	logic signed [31:0] r_q [3][3];
	logic signed [31:0] t_q [3];
	logic signed [31:0] nr_q [3][3];
	logic signed [31:0] nt_q [3];
	logic signed [31:0] tt_q [3];
	logic signed [31:0] tool_q [3];
	logic signed [63:0] prod_q;
	logic signed [35:0] acc_q;
	logic               out_valid_q;

	// angle reduction and quadrant fold
	logic signed [31:0] ang;
	logic signed [33:0] a0, a1, a2;
	logic               fold;

	always_comb begin
		ang = cmd.capture ? in_angle : alpha_q;
		a0  = {{2{ang[31]}}, ang};
		if (a0 > PI_Q)
			a1 = a0 - TWO_PI_Q;
		else if (a0 < -PI_Q)
			a1 = a0 + TWO_PI_Q;
		else
			a1 = a0;
		fold = 1'b1;
		if (a1 > HALF_PI_Q)
			a2 = a1 - PI_Q;
		else if (a1 < -HALF_PI_Q)
			a2 = a1 + PI_Q;
		else begin
			a2   = a1;
			fold = 1'b0;
		end
	end

	logic signed [33:0] dx, dy, at;
	logic signed [33:0] cx, cy;
	logic signed [31:0] cos32, sin32;

	always_comb begin
		dx    = y_q >>> cmd.iter;
		dy    = x_q >>> cmd.iter;
		at    = {2'b00, atan_q(cmd.iter)};
		cx    = cneg_q ? -x_q : x_q;
		cy    = cneg_q ? -y_q : y_q;
		cos32 = sat32({{2{cx[33]}}, cx});
		sin32 = sat32({{2{cy[33]}}, cy});
	end

	// operand selection
	logic signed [31:0] op_a, op_b, op_base;
	logic               op_neg, op_first, op_wr;

	always_comb begin
		op_a     = '0;
		op_b     = '0;
		op_base  = '0;
		op_neg   = 1'b0;
		op_first = 1'b1;
		op_wr    = 1'b1;
		case (cmd.phase)
			PH_LINK: begin
				case (cmd.m)
					3'd0: begin
						op_a   = l_q[1][0];
						op_b   = l_q[2][2];
						op_neg = 1'b1;
					end
					3'd1: begin
						op_a = l_q[1][0];
						op_b = l_q[2][1];
					end
					3'd2: begin
						op_a = l_q[0][0];
						op_b = l_q[2][2];
					end
					3'd3: begin
						op_a   = l_q[0][0];
						op_b   = l_q[2][1];
						op_neg = 1'b1;
					end
					3'd4: begin
						op_a = len_q;
						op_b = l_q[0][0];
					end
					default: begin
						op_a = len_q;
						op_b = l_q[1][0];
					end
				endcase
			end
			PH_ROT: begin
				op_a     = r_q[cmd.i][cmd.k];
				op_b     = l_q[cmd.k][cmd.j];
				op_first = (cmd.k == 2'd0);
				op_wr    = (cmd.k == 2'd2);
			end
			PH_TRN: begin
				op_a     = r_q[cmd.i][cmd.k];
				op_b     = (cmd.k == 2'd0) ? lt_q[0] : (cmd.k == 2'd1) ? lt_q[1] : ofs_q;
				op_base  = t_q[cmd.i];
				op_first = (cmd.k == 2'd0);
				op_wr    = (cmd.k == 2'd2);
			end
			default: begin
				op_a     = nr_q[cmd.i][cmd.k];
				op_b     = tool_q[cmd.k];
				op_base  = nt_q[cmd.i];
				op_first = (cmd.k == 2'd0);
				op_wr    = (cmd.k == 2'd2);
			end
		endcase
	end

	// rounding at the 30-bit shift, ties toward plus infinity
	logic signed [63:0] rsum;
	logic signed [34:0] term;
	logic signed [35:0] acc_next;
	logic signed [31:0] wdat;

	always_comb begin
		rsum     = prod_q + 64'sd536870912;
		term     = op_neg ? -{rsum[63], rsum[63:30]} : {rsum[63], rsum[63:30]};
		acc_next = (op_first ? {{4{op_base[31]}}, op_base} : acc_q) + {term[34], term};
		wdat     = sat32(acc_next);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			len_q   <= in_length;
			ofs_q   <= in_offset;
			alpha_q <= in_twist;
		end
		if (cmd.capture || cmd.cord_load) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= a2;
			cneg_q <= fold;
		end else if (cmd.cord_step) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (cmd.cord_st_theta) begin
			l_q[0][0] <= cos32;
			l_q[1][0] <= sin32;
			l_q[2][0] <= '0;
		end
		if (cmd.cord_st_alpha) begin
			l_q[2][2] <= cos32;
			l_q[2][1] <= sin32;
		end
		if (cmd.mul)
			prod_q <= op_a * op_b;
		if (cmd.acc) begin
			acc_q <= acc_next;
			if (op_wr) begin
				case (cmd.phase)
					PH_LINK: begin
						case (cmd.m)
							3'd0: l_q[0][1] <= wdat;
							3'd1: l_q[0][2] <= wdat;
							3'd2: l_q[1][1] <= wdat;
							3'd3: l_q[1][2] <= wdat;
							3'd4: lt_q[0]   <= wdat;
							default: lt_q[1] <= wdat;
						endcase
					end
					PH_ROT:  nr_q[cmd.i][cmd.j] <= wdat;
					PH_TRN:  nt_q[cmd.i] <= wdat;
					default: tt_q[cmd.i] <= wdat;
				endcase
			end
		end
		if (cmd.emit) begin
			out_link_index <= cmd.link_idx;
			out_row        <= cmd.i;
			out_tool       <= cmd.tool;
			out_col0       <= nr_q[cmd.i][0];
			out_col1       <= nr_q[cmd.i][1];
			out_col2       <= nr_q[cmd.i][2];
			out_col3       <= cmd.tool ? tt_q[cmd.i] : nt_q[cmd.i];
			out_last       <= cmd.last;
		end
	end

	// chain state and tool registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++)
					r_q[a][b] <= (a == b) ? ONE_Q30 : '0;
				t_q[a]    <= '0;
				tool_q[a] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				for (int a = 0; a < 3; a++) begin
					for (int b = 0; b < 3; b++)
						r_q[a][b] <= (a == b) ? ONE_Q30 : '0;
					t_q[a] <= '0;
				end
			end else if (cmd.commit) begin
				r_q <= nr_q;
				t_q <= nt_q;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_TOOL_X: tool_q[0] <= cfg_wdata;
					REG_TOOL_Y: tool_q[1] <= cfg_wdata;
					REG_TOOL_Z: tool_q[2] <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

FILE: design/fkdh_ctrl.sv
// Controller: sequences CORDIC, multiply-accumulate schedule and row output.
`timescale 1ns / 1ps
module fkdh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fkdh_pkg::sts_t sts,
	output fkdh_pkg::cmd_t cmd
);
	import fkdh_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CORD  = 7'b0000010,
		S_CDONE = 7'b0000100,
		S_MUL   = 7'b0001000,
		S_ACC   = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_TAIL  = 7'b1000000
	} state_t;

	state_t          state_q;
	phase_t          ph_q;
	logic [2:0]      m_q;
	logic [1:0]      i_q, j_q, k_q;
	logic [IT_W-1:0] it_q;
	logic            sel_q, tool_q;
	logic [CNT_W-1:0] cnt_q;
	logic            final_link;

	assign final_link = ({1'b0, cnt_q} + 5'd1) >= 5'(NUM_LINKS);
	assign in_ready   = (state_q == S_IDLE);

	always_comb begin
		cmd               = '0;
		cmd.capture       = (state_q == S_IDLE) && in_valid;
		cmd.cord_step     = (state_q == S_CORD);
		cmd.cord_load     = (state_q == S_CDONE) && !sel_q;
		cmd.cord_st_theta = (state_q == S_CDONE) && !sel_q;
		cmd.cord_st_alpha = (state_q == S_CDONE) && sel_q;
		cmd.mul           = (state_q == S_MUL);
		cmd.acc           = (state_q == S_ACC);
		cmd.emit          = (state_q == S_EMIT) && sts.out_free;
		cmd.commit        = (state_q == S_TAIL) && !tool_q;
		cmd.clear         = (state_q == S_TAIL) && tool_q;
		cmd.phase         = ph_q;
		cmd.m             = m_q;
		cmd.i             = i_q;
		cmd.j             = j_q;
		cmd.k             = k_q;
		cmd.iter          = it_q;
		cmd.link_idx      = cnt_q[2:0];
		cmd.tool          = tool_q;
		cmd.last          = (i_q == 2'd2) && (tool_q || !final_link);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_LINK;
			m_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			it_q    <= '0;
			sel_q   <= 1'b0;
			tool_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CORD;
						it_q    <= '0;
						sel_q   <= 1'b0;
						tool_q  <= 1'b0;
					end
				end
				S_CORD: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(CORDIC_ITERS - 1))
						state_q <= S_CDONE;
				end
				S_CDONE: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						it_q    <= '0;
						state_q <= S_CORD;
					end else begin
						ph_q    <= PH_LINK;
						m_q     <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					state_q <= S_MUL;
					case (ph_q)
						PH_LINK: begin
							if (m_q == 3'd5) begin
								ph_q <= PH_ROT;
								i_q  <= '0;
								j_q  <= '0;
								k_q  <= '0;
							end else
								m_q <= m_q + 1'b1;
						end
						PH_ROT: begin
							if (k_q == 2'd2) begin
								k_q <= '0;
								if (j_q == 2'd2) begin
									j_q <= '0;
									if (i_q == 2'd2) begin
										ph_q <= PH_TRN;
										i_q  <= '0;
									end else
										i_q <= i_q + 1'b1;
								end else
									j_q <= j_q + 1'b1;
							end else
								k_q <= k_q + 1'b1;
						end
						default: begin
							if (k_q == 2'd2) begin
								k_q <= '0;
								if (i_q == 2'd2) begin
									i_q     <= '0;
									state_q <= S_EMIT;
								end else
									i_q <= i_q + 1'b1;
							end else
								k_q <= k_q + 1'b1;
						end
					endcase
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (i_q == 2'd2) begin
							i_q <= '0;
							if (!tool_q && final_link) begin
								tool_q  <= 1'b1;
								ph_q    <= PH_TOOL;
								k_q     <= '0;
								state_q <= S_MUL;
							end else
								state_q <= S_TAIL;
						end else
							i_q <= i_q + 1'b1;
					end
				end
				S_TAIL: begin
					cnt_q   <= tool_q ? '0 : cnt_q + 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} < 5'(NUM_LINKS)))
		else $error("link counter beyond chain length");
	a_accept_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CORD))
		else $error("accepted request did not start CORDIC");
	a_tool_final: assert property (@(posedge clk) disable iff (!arst_n)
		(tool_q && state_q != S_IDLE) |-> final_link)
		else $error("tool frame on a non-final link");
`endif

endmodule

FILE: design/forward_kinematics_dh_chain_core.sv
// Top level of the DH forward kinematics chain core.
`timescale 1ns / 1ps
// Takes one link's DH parameters per request and returns three rows of the
// cumulative chain transform; after the last link of the chain it also
// returns the three rows of the end-effector frame with the tool offset and
// then restarts at identity. One request is in flight at a time. A link is
// handled in order by an accept step, two CORDIC passes of 28 iterations
// with a store step each, 42 multiply-accumulates on the single shared
// multiplier, three output rows and a commit step; the last link of a chain
// adds 9 multiply-accumulates for the tool translation and 3 more output
// rows and clears to identity instead of committing; the output side can stall.
module forward_kinematics_dh_chain_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // link_length, link_twist, link_offset, joint_angle
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // link_index, row, col0, col1, col2, col3, zero pad
	output logic [0:0]   m_tuser,   // is_tool_frame
	output logic         m_tlast,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	import fkdh_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	logic [2:0]         link_index;
	logic [1:0]         row;
	logic               is_tool;
	logic signed [31:0] col0, col1, col2, col3;

	fkdh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fkdh_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_length      (s_tdata[31:0]),
		.in_twist       (s_tdata[63:32]),
		.in_offset      (s_tdata[95:64]),
		.in_angle       (s_tdata[127:96]),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_link_index (link_index),
		.out_row        (row),
		.out_tool       (is_tool),
		.out_col0       (col0),
		.out_col1       (col1),
		.out_col2       (col2),
		.out_col3       (col3),
		.out_last       (m_tlast)
	);

	assign m_tdata = {3'b000, col3, col2, col1, col0, row, link_index};
	assign m_tuser = is_tool;

endmodule
